>>> design/bba_pkg.sv
package bba_pkg;

    // Default geometry of the used map
    localparam int NUM_BLOCKS_DEF     = 256;
    localparam int RESERVED_FIRST_DEF = 127;
    localparam int RESERVED_COUNT_DEF = 2;

    // Map storage is organized in rows of ROW_W used bits
    localparam int ROW_W = 32;
    localparam int BIT_W = $clog2(ROW_W);

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_REQUEST = 2'd1,
        CMD_RELEASE = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] block_index;
    } in_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] granted_index;
        logic [8:0] used_count;
        logic [8:0] free_count;
    } out_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic send;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic slot_free;
    } dp_status_t;

endpackage

>>> design/bba_ram.sv
module bba_ram
    import bba_pkg::*;
#(
    parameter int WIDTH = ROW_W,
    parameter int DEPTH = 8
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/bba_ctrl.sv
module bba_ctrl
    import bba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEND
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                // hold until the output register can take the result
                cmd.send = status.slot_free;
                if (status.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/bba_datapath.sv
module bba_datapath
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS     = NUM_BLOCKS_DEF,
    parameter int RESERVED_FIRST = RESERVED_FIRST_DEF,
    parameter int RESERVED_COUNT = RESERVED_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  ctl_cmd_t   cmd,
    output dp_status_t status,
    input  in_t        in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_t       out_data
);

    localparam int ROWS    = (NUM_BLOCKS + ROW_W - 1) / ROW_W;
    localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROWS_P2 = 1 << ROW_AW;
    localparam int BLK_W   = $clog2(NUM_BLOCKS);
    localparam int IDX_W   = ((BLK_W > 8) ? BLK_W : 8) + 1;
    localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);
    localparam int RES_END = (RESERVED_FIRST + RESERVED_COUNT < NUM_BLOCKS) ?
                             (RESERVED_FIRST + RESERVED_COUNT) : NUM_BLOCKS;
    localparam int RES_INIT = (RESERVED_FIRST < NUM_BLOCKS) ?
                              (RES_END - RESERVED_FIRST) : 0;

    // Row contents after reset: reserved blocks set, padding past the map set
    function automatic logic [ROW_W-1:0] reset_row(input logic [ROW_AW-1:0] row);
        logic [ROW_W-1:0] r;
        int               blk;
        r = '0;
        for (int b = 0; b < ROW_W; b++)
        begin
            blk  = int'(row) * ROW_W + b;
            r[b] = (blk >= NUM_BLOCKS) ||
                   ((blk >= RESERVED_FIRST) && (blk < RESERVED_FIRST + RESERVED_COUNT));
        end
        return r;
    endfunction

    logic [1:0]        cmd_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              inrange_reg;
    logic              nofree_reg;
    logic [ROW_AW-1:0] row_reg;
    logic [CNT_W-1:0]  used_total_reg;
    logic [CNT_W-1:0]  used_total_next;
    logic              full_reg  [ROWS_P2];
    logic              rvalid_reg [ROWS_P2];
    out_t              res_reg;
    out_t              res_next;
    out_t              out_reg;
    logic              out_valid_reg;

    logic [IDX_W-1:0]  idx_ext;
    logic [ROW_AW-1:0] free_row;
    logic              any_free;
    logic [ROW_AW-1:0] rd_row;
    logic [ROW_W-1:0]  rdata;
    logic [ROW_W-1:0]  row_data;
    logic [ROW_W-1:0]  row_new;
    logic [BIT_W-1:0]  zero_bit;
    logic [BIT_W-1:0]  sel_bit;
    logic              wr_en;

    assign idx_ext = IDX_W'(in_data.block_index);
    assign sel_bit = idx_reg[BIT_W-1:0];

    // Lowest row with a free block
    always_comb
    begin
        free_row = '0;
        any_free = 1'b0;
        for (int k = ROWS_P2 - 1; k >= 0; k--)
        begin
            if (!full_reg[k])
            begin
                free_row = ROW_AW'(k);
                any_free = 1'b1;
            end
        end
    end

    assign rd_row = (cmd_t'(in_data.command) == CMD_ALLOC) ? free_row :
                    ROW_AW'(idx_ext >> BIT_W);

    bba_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS_P2)
    ) u_map (
        .clk   (clk),
        .we    (wr_en),
        .waddr (row_reg),
        .wdata (row_new),
        .re    (cmd.accept),
        .raddr (rd_row),
        .rdata (rdata)
    );

    // Rows never written read as their reset contents
    assign row_data = rvalid_reg[row_reg] ? rdata : reset_row(row_reg);

    always_comb
    begin
        zero_bit = '0;
        for (int b = ROW_W - 1; b >= 0; b--)
        begin
            if (!row_data[b])
            begin
                zero_bit = BIT_W'(b);
            end
        end
    end

    always_comb
    begin
        res_next        = '0;
        row_new         = row_data;
        wr_en           = 1'b0;
        used_total_next = used_total_reg;
        case (cmd_t'(cmd_reg))
            CMD_ALLOC:
            begin
                if (!nofree_reg)
                begin
                    row_new[zero_bit]      = 1'b1;
                    wr_en                  = cmd.exec;
                    used_total_next        = used_total_reg + CNT_W'(1);
                    res_next.ok            = 1'b1;
                    res_next.granted_index = 8'({row_reg, zero_bit});
                end
            end
            CMD_REQUEST:
            begin
                if (inrange_reg && !row_data[sel_bit])
                begin
                    row_new[sel_bit]       = 1'b1;
                    wr_en                  = cmd.exec;
                    used_total_next        = used_total_reg + CNT_W'(1);
                    res_next.ok            = 1'b1;
                    res_next.granted_index = idx_reg[7:0];
                end
            end
            CMD_RELEASE:
            begin
                res_next.ok = 1'b1;
                if (inrange_reg && row_data[sel_bit])
                begin
                    row_new[sel_bit] = 1'b0;
                    wr_en            = cmd.exec;
                    used_total_next  = used_total_reg - CNT_W'(1);
                end
            end
            default:
            begin
                res_next.ok = 1'b0;
            end
        endcase
        res_next.used_count = 9'(used_total_next);
        res_next.free_count = 9'(CNT_W'(NUM_BLOCKS) - used_total_next);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg     <= in_data.command;
            idx_reg     <= idx_ext;
            inrange_reg <= idx_ext < IDX_W'(NUM_BLOCKS);
            nofree_reg  <= !any_free;
            row_reg     <= rd_row;
        end
        if (cmd.exec)
        begin
            res_reg <= res_next;
        end
        if (cmd.send)
        begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_total_reg <= CNT_W'(RES_INIT);
            out_valid_reg  <= 1'b0;
            for (int k = 0; k < ROWS_P2; k++)
            begin
                rvalid_reg[k] <= 1'b0;
                full_reg[k]   <= &reset_row(ROW_AW'(k));
            end
        end
        else
        begin
            if (cmd.exec)
            begin
                used_total_reg <= used_total_next;
            end
            if (wr_en)
            begin
                rvalid_reg[row_reg] <= 1'b1;
                full_reg[row_reg]   <= &row_new;
            end
            if (cmd.send)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.slot_free = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign out_data         = out_reg;

endmodule

>>> design/bitmap_block_allocator.sv
// First-fit block allocator over a one-bit-per-block used map. Each input
// transfer carries one command (allocate lowest free, request a named block,
// release a named block) and produces exactly one result transfer with the
// success flag, the granted block and the used and free counts afterward.
// From input transfer to result load, the accept cycle picks the map row
// (lowest non-full row for allocate, the named row otherwise) and starts its
// read from the map RAM, the next cycle decides and writes the row back, and
// the send state loads the output register once that register is free. The
// map RAM has registered reads. A new input transfer is taken while an earlier
// result still waits in the output register. Reset takes effect at once: each
// map row has a valid bit, and a row never written reads as its reset contents
// (reserved blocks set), so there is no clearing pass.
module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS     = NUM_BLOCKS_DEF,
    parameter int RESERVED_FIRST = RESERVED_FIRST_DEF,
    parameter int RESERVED_COUNT = RESERVED_COUNT_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    ctl_cmd_t   ctl_cmd;
    dp_status_t dp_status;

    // Sequence one command at a time: accept, execute, deliver
    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (dp_status),
        .cmd      (ctl_cmd)
    );

    // Hold the map, the row summaries, the count and the output register
    bba_datapath #(
        .NUM_BLOCKS     (NUM_BLOCKS),
        .RESERVED_FIRST (RESERVED_FIRST),
        .RESERVED_COUNT (RESERVED_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ctl_cmd),
        .status    (dp_status),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
